// ===== hw/rtl/rsps_pkg.sv =====
// Package for the ramp/soak profile sequencer.
// Holds the controller state type, item kind, run mode and ramp direction codes.
// No dependencies.
package rsps_pkg;

    localparam int MAX_STEPS_DEF = 16;
    localparam logic [15:0] AMBIENT_RESET = 16'd20;

    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_STOP  = 3'd2;
    localparam logic [2:0] KIND_RESET = 3'd3;
    localparam logic [2:0] KIND_LOAD  = 3'd4;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_DONE = 2'd2;
    localparam logic [1:0] MODE_STOP = 2'd3;

    localparam logic [1:0] DIR_HEAT = 2'd0;
    localparam logic [1:0] DIR_COOL = 2'd1;
    localparam logic [1:0] DIR_HOLD = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CATCH,
        ST_INTERP,
        ST_MUL,
        ST_DIV,
        ST_APPLY,
        ST_CHECK,
        ST_ADV,
        ST_RESULT
    } seq_state_t;

endpackage

// ===== hw/rtl/ramp_soak_profile_sequencer.sv =====
// Top level of the ramp/soak profile sequencer: control sequencer, step table,
// bit-serial multiplier and restoring divider for the target interpolation.
// Depends on rsps_pkg.

// A request is taken when start is high and busy is low; every request gives
// exactly one result, shown for one cycle with done high, and the receiver
// cannot hold it off. A tick that interpolates runs a 16-bit shift-add multiply
// of the temperature span by the elapsed seconds and a restoring divide by the
// step duration, one bit per cycle each, and a tick that moves to the next step
// also reads the table in ST_ADV. The step table clears at reset through
// per-entry valid bits, so no clearing pass is needed. busy stays high from
// acceptance until done.
module ramp_soak_profile_sequencer
    import rsps_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [3:0]  step_index,
    input  logic [15:0] step_setpoint,
    input  logic [15:0] step_duration,
    input  logic [7:0]  step_flags,
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic [1:0]  run_state,
    output logic [4:0]  step_number,
    output logic [15:0] target_temp,
    output logic [7:0]  drive_flags,
    output logic [1:0]  ramp_direction,
    output logic [31:0] profile_seconds,
    output logic [15:0] step_seconds
);

    localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int PW = $clog2(MAX_STEPS + 1);
    localparam logic [4:0] MUL_LAST = 5'd15;
    localparam logic [4:0] DIV_LAST = 5'd31;

    seq_state_t state_reg, state_next;

    logic [2:0]  kind_reg;
    logic [3:0]  idx_reg;
    logic [15:0] sp_in_reg;
    logic [15:0] dur_in_reg;
    logic [7:0]  flg_in_reg;

    logic [15:0] ambient_reg;
    logic [1:0]  mode_reg, mode_next;
    logic [PW-1:0] ptr_reg, ptr_next;
    logic [15:0] ramp_reg, ramp_next;
    logic [15:0] target_reg, target_next;
    logic [31:0] total_reg, total_next;
    logic [15:0] sis_reg, sis_next;
    logic [7:0]  flags_reg, flags_next;
    logic [15:0] cur_sp_reg, cur_sp_next;
    logic [15:0] cur_dur_reg, cur_dur_next;
    logic        neg_reg, neg_next;
    logic [15:0] mcand_reg, mcand_next;
    logic [31:0] prod_reg, prod_next;
    logic [15:0] rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;

    // Step table: {setpoint, duration, flags}, with valid bits cleared at reset.
    logic [39:0] mem [MAX_STEPS];
    logic [MAX_STEPS-1:0] vld_reg;
    logic [39:0] rd_q_reg;
    logic        rd_vld_reg;
    logic [AW-1:0] rd_addr;
    logic        mem_we;
    logic [AW-1:0] wr_addr;
    logic [39:0] rd_data;

    logic [16:0] diff;
    logic [16:0] mul_sum;
    logic [16:0] div_trial;
    logic        div_fit;
    logic [32:0] pos_sum;
    logic [PW-1:0] ptr_inc;
    logic        load_hit;

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign run_state       = mode_reg;
    assign step_number     = 5'(ptr_reg);
    assign target_temp     = target_reg;
    assign drive_flags     = flags_reg;
    assign profile_seconds = total_reg;
    assign step_seconds    = sis_reg;

    always_comb
    begin
        if (32'(ptr_reg) >= MAX_STEPS)
            ramp_direction = DIR_HOLD;
        else if (cur_sp_reg > ramp_reg)
            ramp_direction = DIR_HEAT;
        else if (cur_sp_reg < ramp_reg)
            ramp_direction = DIR_COOL;
        else
            ramp_direction = DIR_HOLD;
    end

    assign rd_data   = rd_vld_reg ? rd_q_reg : 40'd0;
    assign wr_addr   = AW'(idx_reg);
    assign diff      = {1'b0, cur_sp_reg} - {1'b0, ramp_reg};
    assign mul_sum   = {1'b0, prod_reg[31:16]} + (prod_reg[0] ? {1'b0, mcand_reg} : 17'd0);
    assign div_trial = {rem_reg, prod_reg[31]};
    assign div_fit   = (div_trial >= {1'b0, cur_dur_reg});
    assign pos_sum   = {17'd0, ramp_reg} + {1'b0, prod_reg};
    assign ptr_inc   = ptr_reg + PW'(1);
    assign load_hit  = (32'(ptr_reg) == 32'(idx_reg));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= {sp_in_reg, dur_in_reg, flg_in_reg};
        rd_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
                vld_reg[wr_addr] <= 1'b1;
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            kind_reg    <= KIND_TICK;
            idx_reg     <= '0;
            sp_in_reg   <= '0;
            dur_in_reg  <= '0;
            flg_in_reg  <= '0;
            ambient_reg <= AMBIENT_RESET;
            mode_reg    <= MODE_IDLE;
            ptr_reg     <= '0;
            ramp_reg    <= '0;
            target_reg  <= '0;
            total_reg   <= '0;
            sis_reg     <= '0;
            flags_reg   <= '0;
            cur_sp_reg  <= '0;
            cur_dur_reg <= '0;
            neg_reg     <= 1'b0;
            mcand_reg   <= '0;
            prod_reg    <= '0;
            rem_reg     <= '0;
            cnt_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            if (start && !busy)
            begin
                kind_reg   <= kind;
                idx_reg    <= step_index;
                sp_in_reg  <= step_setpoint;
                dur_in_reg <= step_duration;
                flg_in_reg <= step_flags;
            end
            if (cfg_write)
                ambient_reg <= cfg_data;
            mode_reg    <= mode_next;
            ptr_reg     <= ptr_next;
            ramp_reg    <= ramp_next;
            target_reg  <= target_next;
            total_reg   <= total_next;
            sis_reg     <= sis_next;
            flags_reg   <= flags_next;
            cur_sp_reg  <= cur_sp_next;
            cur_dur_reg <= cur_dur_next;
            neg_reg     <= neg_next;
            mcand_reg   <= mcand_next;
            prod_reg    <= prod_next;
            rem_reg     <= rem_next;
            cnt_reg     <= cnt_next;
            done_reg    <= done_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        ptr_next     = ptr_reg;
        ramp_next    = ramp_reg;
        target_next  = target_reg;
        total_next   = total_reg;
        sis_next     = sis_reg;
        flags_next   = flags_reg;
        cur_sp_next  = cur_sp_reg;
        cur_dur_next = cur_dur_reg;
        neg_next     = neg_reg;
        mcand_next   = mcand_reg;
        prod_next    = prod_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        mem_we       = 1'b0;
        rd_addr      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_DECODE;
            end

            ST_DECODE:
            begin
                state_next = ST_RESULT;
                case (mode_reg)
                    MODE_IDLE:
                    begin
                        if (kind_reg == KIND_START)
                        begin
                            ptr_next   = '0;
                            total_next = '0;
                            sis_next   = '0;
                            ramp_next  = ambient_reg;
                            mode_next  = MODE_RUN;
                            state_next = ST_CATCH;
                        end
                        else if (kind_reg == KIND_LOAD && 32'(idx_reg) < MAX_STEPS)
                        begin
                            mem_we = 1'b1;
                            // Keep the cached current step in line with the table.
                            if (load_hit)
                            begin
                                cur_sp_next  = sp_in_reg;
                                cur_dur_next = dur_in_reg;
                            end
                        end
                    end
                    MODE_RUN:
                    begin
                        if (kind_reg == KIND_STOP)
                        begin
                            flags_next = '0;
                            mode_next  = MODE_STOP;
                        end
                        else
                        begin
                            total_next = total_reg + 32'd1;
                            if (sis_reg != 16'hFFFF)
                                sis_next = sis_reg + 16'd1;
                            state_next = ST_INTERP;
                        end
                    end
                    default:
                    begin
                        if (kind_reg == KIND_RESET)
                            mode_next = MODE_IDLE;
                    end
                endcase
            end

            ST_CATCH:
            begin
                cur_sp_next  = rd_data[39:24];
                cur_dur_next = rd_data[23:8];
                flags_next   = rd_data[7:0];
                state_next   = ST_RESULT;
            end

            ST_INTERP:
            begin
                if (cur_dur_reg == 16'd0)
                begin
                    target_next = cur_sp_reg;
                    state_next  = ST_CHECK;
                end
                else
                begin
                    neg_next   = diff[16];
                    mcand_next = diff[16] ? 16'(-diff) : diff[15:0];
                    prod_next  = {16'd0, sis_reg};
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                // Shift-add: add the span into the high half, shift right one bit.
                prod_next = {mul_sum, prod_reg[15:1]};
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == MUL_LAST)
                begin
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                // Restoring divide; the quotient shifts in where the dividend leaves.
                rem_next  = div_fit ? 16'(div_trial - {1'b0, cur_dur_reg}) : div_trial[15:0];
                prod_next = {prod_reg[30:0], div_fit};
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                    state_next = ST_APPLY;
            end

            ST_APPLY:
            begin
                if (neg_reg)
                    target_next = (prod_reg > {16'd0, ramp_reg}) ? 16'd0
                                                                 : ramp_reg - prod_reg[15:0];
                else
                    target_next = (pos_sum[32:16] != 17'd0) ? 16'hFFFF : pos_sum[15:0];
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                state_next = ST_RESULT;
                if (sis_reg >= cur_dur_reg)
                begin
                    if (32'(ptr_inc) >= MAX_STEPS)
                    begin
                        ptr_next  = PW'(MAX_STEPS);
                        mode_next = MODE_DONE;
                    end
                    else
                    begin
                        ptr_next   = ptr_inc;
                        rd_addr    = AW'(ptr_inc);
                        state_next = ST_ADV;
                    end
                end
            end

            ST_ADV:
            begin
                cur_sp_next  = rd_data[39:24];
                cur_dur_next = rd_data[23:8];
                if (rd_data[39:24] == 16'd0 && rd_data[23:8] == 16'd0)
                    mode_next = MODE_DONE;
                else
                begin
                    // The new step ramps from the setpoint of the one just ended.
                    ramp_next  = cur_sp_reg;
                    sis_next   = '0;
                    flags_next = rd_data[7:0];
                end
                state_next = ST_RESULT;
            end

            ST_RESULT:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== bench/rsps_profile_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the ramp/soak profile sequencer: tracks requests and ambient
// writes, predicts the status report of each request and checks it at done.
// Depends on rsps_pkg.
module rsps_profile_checker
    import rsps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  kind,
    input  logic [3:0]  step_index,
    input  logic [15:0] step_setpoint,
    input  logic [15:0] step_duration,
    input  logic [7:0]  step_flags,
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    input  logic        done,
    input  logic [1:0]  run_state,
    input  logic [4:0]  step_number,
    input  logic [15:0] target_temp,
    input  logic [7:0]  drive_flags,
    input  logic [1:0]  ramp_direction,
    input  logic [31:0] profile_seconds,
    input  logic [15:0] step_seconds,
    output int          errors,
    output int          outstanding
);

    localparam int STEPS = MAX_STEPS_DEF;

    typedef struct {
        logic [1:0]  run_state;
        logic [4:0]  step_number;
        logic [15:0] target_temp;
        logic [7:0]  drive_flags;
        logic [1:0]  ramp_direction;
        logic [31:0] profile_seconds;
        logic [15:0] step_seconds;
    } profile_status_t;

    profile_status_t status_q[$];
    int mismatches = 0;

    logic [15:0] ambient;
    logic [1:0]  mode;
    logic [4:0]  ptr;
    logic [15:0] ramp_from;
    logic [15:0] target;
    logic [31:0] total;
    logic [15:0] secs;
    logic [7:0]  flags;
    logic [15:0] tbl_setpoint [STEPS];
    logic [15:0] tbl_duration [STEPS];
    logic [7:0]  tbl_flags [STEPS];

    function automatic void clear_profile();
        ambient = AMBIENT_RESET;
        mode = MODE_IDLE;
        ptr = '0;
        ramp_from = '0;
        target = '0;
        total = '0;
        secs = '0;
        flags = '0;
        for (int i = 0; i < STEPS; i++)
        begin
            tbl_setpoint[i] = '0;
            tbl_duration[i] = '0;
            tbl_flags[i] = '0;
        end
    endfunction

    // Linear ramp from the step's start temperature; the division truncates
    // toward zero on a negative span.
    function automatic void interpolate_target();
        longint from_v, to_v, dur_v, el_v, val;
        if (ptr >= STEPS)
            return;
        from_v = longint'(ramp_from);
        to_v = longint'(tbl_setpoint[ptr[3:0]]);
        dur_v = longint'(tbl_duration[ptr[3:0]]);
        el_v = longint'(secs);
        if (dur_v == 0)
        begin
            target = tbl_setpoint[ptr[3:0]];
            return;
        end
        val = from_v + ((to_v - from_v) * el_v) / dur_v;
        if (val < 0)
            val = 0;
        if (val > 65535)
            val = 65535;
        target = val[15:0];
    endfunction

    function automatic void advance_step();
        logic [4:0] nxt;
        nxt = ptr + 5'd1;
        ptr = nxt;
        if (nxt >= STEPS)
        begin
            ptr = 5'(STEPS);
            mode = MODE_DONE;
        end
        else if (tbl_setpoint[nxt[3:0]] == '0 && tbl_duration[nxt[3:0]] == '0)
        begin
            mode = MODE_DONE;
        end
        else
        begin
            ramp_from = tbl_setpoint[nxt[3:0] - 4'd1];
            secs = '0;
            flags = tbl_flags[nxt[3:0]];
        end
    endfunction

    function automatic logic [1:0] heading();
        if (ptr >= STEPS)
            return DIR_HOLD;
        if (tbl_setpoint[ptr[3:0]] > ramp_from)
            return DIR_HEAT;
        if (tbl_setpoint[ptr[3:0]] < ramp_from)
            return DIR_COOL;
        return DIR_HOLD;
    endfunction

    function automatic void apply_request(input logic [2:0] k, input logic [3:0] idx,
                                          input logic [15:0] sp, input logic [15:0] dur,
                                          input logic [7:0] flg);
        profile_status_t st;
        if (mode == MODE_IDLE)
        begin
            if (k == KIND_START)
            begin
                ptr = '0;
                total = '0;
                secs = '0;
                ramp_from = ambient;
                flags = tbl_flags[0];
                mode = MODE_RUN;
            end
            else if (k == KIND_LOAD)
            begin
                tbl_setpoint[idx] = sp;
                tbl_duration[idx] = dur;
                tbl_flags[idx] = flg;
            end
        end
        else if (mode == MODE_RUN)
        begin
            // While running, every request other than stop is one second.
            if (k == KIND_STOP)
            begin
                flags = '0;
                mode = MODE_STOP;
            end
            else
            begin
                total = total + 32'd1;
                if (secs != 16'hFFFF)
                    secs = secs + 16'd1;
                interpolate_target();
                if (ptr >= STEPS || secs >= tbl_duration[ptr[3:0]])
                    advance_step();
            end
        end
        else if (k == KIND_RESET)
        begin
            mode = MODE_IDLE;
        end
        st.run_state = mode;
        st.step_number = ptr;
        st.target_temp = target;
        st.drive_flags = flags;
        st.ramp_direction = heading();
        st.profile_seconds = total;
        st.step_seconds = secs;
        status_q.push_back(st);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    function automatic void check_status();
        profile_status_t want;
        if (status_q.size() == 0)
        begin
            $error("status report with no request outstanding");
            mismatches++;
            return;
        end
        want = status_q.pop_front();
        check_field("run_state", 32'(want.run_state), 32'(run_state));
        check_field("step_number", 32'(want.step_number), 32'(step_number));
        check_field("target_temp", 32'(want.target_temp), 32'(target_temp));
        check_field("drive_flags", 32'(want.drive_flags), 32'(drive_flags));
        check_field("ramp_direction", 32'(want.ramp_direction), 32'(ramp_direction));
        check_field("profile_seconds", want.profile_seconds, profile_seconds);
        check_field("step_seconds", 32'(want.step_seconds), 32'(step_seconds));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_profile();
            status_q.delete();
        end
        else
        begin
            if (cfg_write)
                ambient = cfg_data;
            // The report of an older request is checked before a request
            // taken at the same edge is predicted.
            if (done)
                check_status();
            if (start && !busy)
                apply_request(kind, step_index, step_setpoint, step_duration, step_flags);
        end
        outstanding <= status_q.size();
        errors <= mismatches;
    end

endmodule

// ===== bench/ramp_soak_profile_sequencer_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the ramp/soak profile sequencer: clock, reset, directed and
// random profile requests in bursts, ambient writes between phases, verdict.
// Depends on rsps_pkg, ramp_soak_profile_sequencer and rsps_profile_checker.
module ramp_soak_profile_sequencer_tb;
    import rsps_pkg::*;

    localparam int STEPS = MAX_STEPS_DEF;
    localparam int RANDOM_REQUESTS = 550;
    localparam int PHASES = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  kind = KIND_TICK;
    logic [3:0]  step_index = '0;
    logic [15:0] step_setpoint = '0;
    logic [15:0] step_duration = '0;
    logic [7:0]  step_flags = '0;
    logic        cfg_write = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        busy;
    logic        done;
    logic [1:0]  run_state;
    logic [4:0]  step_number;
    logic [15:0] target_temp;
    logic [7:0]  drive_flags;
    logic [1:0]  ramp_direction;
    logic [31:0] profile_seconds;
    logic [15:0] step_seconds;
    int          errors;
    int          outstanding;

    int requests_sent = 0;
    int burst_left = 0;

    always #6 clk = ~clk;

    ramp_soak_profile_sequencer uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .step_index(step_index), .step_setpoint(step_setpoint),
        .step_duration(step_duration), .step_flags(step_flags),
        .cfg_write(cfg_write), .cfg_data(cfg_data), .done(done),
        .run_state(run_state), .step_number(step_number), .target_temp(target_temp),
        .drive_flags(drive_flags), .ramp_direction(ramp_direction),
        .profile_seconds(profile_seconds), .step_seconds(step_seconds)
    );

    rsps_profile_checker scoreboard (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .step_index(step_index), .step_setpoint(step_setpoint),
        .step_duration(step_duration), .step_flags(step_flags),
        .cfg_write(cfg_write), .cfg_data(cfg_data), .done(done),
        .run_state(run_state), .step_number(step_number), .target_temp(target_temp),
        .drive_flags(drive_flags), .ramp_direction(ramp_direction),
        .profile_seconds(profile_seconds), .step_seconds(step_seconds),
        .errors(errors), .outstanding(outstanding)
    );

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send(input logic [2:0] k, input logic [3:0] idx,
                        input logic [15:0] sp, input logic [15:0] dur,
                        input logic [7:0] flg, input bit counted);
        int gap;
        int r;
        if (burst_left == 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                gap = $urandom_range(1, 3);
            else if (r < 85)
                gap = $urandom_range(4, 20);
            else
                gap = $urandom_range(21, 70);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        start <= 1'b1;
        kind <= k;
        step_index <= idx;
        step_setpoint <= sp;
        step_duration <= dur;
        step_flags <= flg;
        do
            @(posedge clk);
        while (busy);
        if (counted)
            requests_sent++;
    endtask

    // A request whose step fields carry only noise.
    task automatic send_kind(input logic [2:0] k, input bit counted);
        send(k, 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), counted);
    endtask

    task automatic load_step(input int idx, input logic [15:0] sp,
                             input logic [15:0] dur, input logic [7:0] flg);
        send(KIND_LOAD, 4'(idx), sp, dur, flg, 1'b1);
    endtask

    // Any kind other than stop counts as one second while running.
    function automatic logic [2:0] second_kind();
        logic [2:0] k;
        if ($urandom_range(0, 9) < 6)
            return KIND_TICK;
        k = 3'($urandom_range(0, 7));
        if (k == KIND_STOP)
            k = KIND_TICK;
        return k;
    endfunction

    function automatic logic [15:0] pick_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 16'($urandom_range(0, 4));
        if (r < 85)
            return 16'($urandom_range(5, 30));
        if (r < 95)
            return 16'($urandom);
        return 16'hFFFF;
    endfunction

    function automatic logic [15:0] pick_setpoint(input logic [15:0] prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return prev;
        if (r < 20)
            return 16'h0000;
        if (r < 30)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    task automatic quiesce();
        start <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    task automatic write_ambient(input logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_data <= 16'($urandom);
    endtask

    task automatic directed_requests();
        send_kind(KIND_TICK, 1'b0);
        send_kind(KIND_STOP, 1'b0);
        send_kind(KIND_RESET, 1'b0);
        send_kind(3'b111, 1'b0);
        load_step(0, 16'hFFFF, 16'd3, 8'hFF);
        load_step(1, 16'h0000, 16'd2, 8'h00);
        load_step(2, 16'd500, 16'd0, 8'hA5);
        load_step(15, 16'h8000, 16'hFFFF, 8'h5A);
        load_step(3, 16'h0000, 16'd0, 8'h3C);
        send_kind(KIND_START, 1'b0);
        // A load while running is just another second.
        send(KIND_LOAD, 4'd9, 16'h1234, 16'h4321, 8'hC3, 1'b0);
        send_kind(3'd5, 1'b0);
        send_kind(3'd6, 1'b0);
        send_kind(3'd7, 1'b0);
        send_kind(KIND_START, 1'b0);
        send_kind(KIND_RESET, 1'b0);
        send_kind(KIND_TICK, 1'b0);
        send_kind(KIND_START, 1'b0);
        send_kind(KIND_STOP, 1'b0);
        send_kind(KIND_RESET, 1'b0);
        send_kind(KIND_START, 1'b0);
        send_kind(KIND_STOP, 1'b0);
        send_kind(KIND_TICK, 1'b0);
        send_kind(KIND_RESET, 1'b0);
    endtask

    // One profile: reset (to idle from done or stop), load a short table (or the
    // whole table so the run falls off its end), start, run some seconds and maybe stop.
    task automatic run_profile();
        int n_steps;
        int n_seconds;
        int span;
        logic [15:0] sp;
        logic [15:0] dur;
        bit whole_table;
        whole_table = ($urandom_range(0, 7) == 0);
        n_steps = whole_table ? STEPS : $urandom_range(1, 5);
        span = 0;
        sp = 16'($urandom);
        send_kind(KIND_RESET, 1'b1);
        if ($urandom_range(0, 4) == 0)
            send_kind(($urandom_range(0, 1) == 0) ? KIND_TICK : KIND_STOP, 1'b0);
        for (int i = 0; i < n_steps; i++)
        begin
            sp = pick_setpoint(sp);
            dur = whole_table ? 16'($urandom_range(0, 3)) : pick_duration();
            if (sp == '0 && dur == '0)
                dur = 16'd1;
            span += (dur == '0) ? 1 : int'(dur);
            load_step(i, sp, dur, 8'($urandom));
        end
        if (!whole_table && $urandom_range(0, 3) != 0)
            load_step(n_steps, 16'h0000, 16'h0000, 8'($urandom));
        if ($urandom_range(0, 2) == 0)
            send(KIND_LOAD, 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), 1'b1);
        send_kind(KIND_START, 1'b1);
        n_seconds = whole_table ? span + $urandom_range(0, 3) : $urandom_range(1, 40);
        for (int i = 0; i < n_seconds; i++)
            send_kind(second_kind(), 1'b1);
        if ($urandom_range(0, 1) == 0)
        begin
            send_kind(KIND_STOP, 1'b1);
            if ($urandom_range(0, 2) == 0)
                send_kind(second_kind(), 1'b0);
        end
    endtask

    initial
    begin
        logic [15:0] ambient_points [PHASES];
        ambient_points = '{16'd0, 16'hFFFF, 16'h8000, 16'd20, 16'($urandom), 16'($urandom)};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        directed_requests();
        for (int ph = 0; ph < PHASES; ph++)
        begin
            quiesce();
            write_ambient(ambient_points[ph]);
            while (requests_sent < (ph + 1) * RANDOM_REQUESTS / PHASES)
                run_profile();
        end
        quiesce();
        if (errors == 0)
            $display("ramp_soak_profile_sequencer verification clean");
        else
            $display("ramp_soak_profile_sequencer verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("ramp_soak_profile_sequencer verification failed");
        $finish;
    end

endmodule
